// ===== src/ptf_pkg.sv =====
// Shared widths, constants, codes and types for the pressure trend forecast core.
package ptf_pkg;

  // payload widths
  localparam int unsigned P_W    = 17;  // pressure in Pa
  localparam int unsigned TEMP_W = 15;  // temperature, 0.01 degC, signed
  localparam int unsigned TS_W   = 32;  // timestamp in ms
  localparam int unsigned MMHG_W = 17;
  localparam int unsigned DENS_W = 16;
  localparam int unsigned TRND_W = 16;
  localparam int unsigned FC_W   = 2;

  // register widths
  localparam int unsigned THR_W  = 15;
  localparam int unsigned SPAN_W = 16;

  // serial arithmetic widths
  localparam int unsigned MUL_A_W = 27;  // widest constant multiplicand
  localparam int unsigned MUL_B_W = 17;  // bit-serial multiplier operand
  localparam int unsigned PROD_W  = 44;  // product and dividend width
  localparam int unsigned DEN_W   = 32;  // divisor width

  localparam int unsigned HIST_DEPTH_DEF = 16;

  // scale constants
  localparam logic [MUL_A_W-1:0] MMHG_MUL    = MUL_A_W'(75006);
  localparam logic [PROD_W-1:0]  MMHG_RND    = PROD_W'(50000);
  localparam logic [DEN_W-1:0]   MMHG_DIV    = DEN_W'(100000);
  localparam logic [MUL_A_W-1:0] DENS_SCALE  = MUL_A_W'(100000000);
  localparam logic [MUL_A_W-1:0] DENS_GAS    = MUL_A_W'(28705);
  localparam logic [P_W-1:0]     KELVIN_OFS  = P_W'(27315);
  localparam logic [MUL_A_W-1:0] TREND_SCALE = MUL_A_W'(3600000);

  // register reset values
  localparam logic              RST_SENSOR_READY = 1'b0;
  localparam logic [THR_W-1:0]  RST_THRESHOLD    = THR_W'(50);
  localparam logic [SPAN_W-1:0] RST_MIN_SPAN     = SPAN_W'(1000);
  localparam logic [P_W-1:0]    RST_P_LOW        = P_W'(30000);
  localparam logic [P_W-1:0]    RST_P_HIGH       = P_W'(120000);

  // register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_SENSOR_READY = 3'd0,
    REG_THRESHOLD    = 3'd1,
    REG_MIN_SPAN     = 3'd2,
    REG_P_LOW        = 3'd3,
    REG_P_HIGH       = 3'd4
  } reg_idx_t;

  // forecast classes
  localparam logic [FC_W-1:0] FC_NONE   = 2'd0;
  localparam logic [FC_W-1:0] FC_CLEAR  = 2'd1;
  localparam logic [FC_W-1:0] FC_CHANGE = 2'd2;
  localparam logic [FC_W-1:0] FC_RAIN   = 2'd3;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;  // one-cycle pulse, result valid and held
  } unit_stat_t;

endpackage

// ===== src/ptf_smul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module ptf_smul import ptf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [PROD_W-1:0]  prod,
  output unit_stat_t         stat
);

  localparam int unsigned CNT_W = $clog2(MUL_B_W + 1);

  logic [CNT_W-1:0]   cnt;
  logic [PROD_W-1:0]  a_sh;
  logic [MUL_B_W-1:0] b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CNT_W'(MUL_B_W);
      end else if (stat.busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= '0;
      a_sh <= PROD_W'(a);
      b_sh <= b;
    end else if (stat.busy) begin
      if (b_sh[0]) begin
        prod <= prod + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule

// ===== src/ptf_sdiv.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module ptf_sdiv import ptf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] num,
  input  logic [DEN_W-1:0]  den,
  output logic [PROD_W-1:0] quo,
  output unit_stat_t        stat
);

  localparam int unsigned CNT_W = $clog2(PROD_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic             ge;

  // quotient bits shift into the low end as dividend bits leave the top
  assign trial = {rem, quo[PROD_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CNT_W'(PROD_W);
      end else if (stat.busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      den_r <= den;
      rem   <= '0;
    end else if (stat.busy) begin
      rem <= ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo <= {quo[PROD_W-2:0], ge};
    end
  end

endmodule

// ===== src/ptf_hist.sv =====
// Ring history of accepted pressure/time samples with oldest-entry readout.
module ptf_hist import ptf_pkg::*; #(
  parameter int unsigned DEPTH = HIST_DEPTH_DEF,
  localparam int unsigned IDX_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [P_W-1:0]   push_pressure,
  input  logic [TS_W-1:0]  push_time,
  input  logic             fetch,
  output logic [P_W-1:0]   old_pressure,
  output logic [TS_W-1:0]  old_time,
  output logic [CNT_W-1:0] fill
);

  logic [P_W+TS_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0]    wr_idx;
  logic [CNT_W:0]      old_sum;
  logic [CNT_W:0]      old_wrap;
  logic [IDX_W-1:0]    rd_idx;

  // oldest = (wr_idx + DEPTH - fill) mod DEPTH
  assign old_sum  = (CNT_W+1)'(wr_idx) + (CNT_W+1)'(DEPTH) - (CNT_W+1)'(fill);
  assign old_wrap = (old_sum >= (CNT_W+1)'(DEPTH)) ? old_sum - (CNT_W+1)'(DEPTH) : old_sum;
  assign rd_idx   = old_wrap[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      fill   <= '0;
    end else if (push) begin
      wr_idx <= (wr_idx == IDX_W'(DEPTH - 1)) ? '0 : wr_idx + IDX_W'(1);
      if (fill != CNT_W'(DEPTH)) begin
        fill <= fill + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_idx] <= {push_pressure, push_time};
    end
  end

  always_ff @(posedge clk) begin
    if (fetch) begin
      {old_pressure, old_time} <= mem[rd_idx];
    end
  end

endmodule

// ===== src/pressure_trend_forecast_core.sv =====
// Top level: pressure trend forecast core with stream ports and register port.
//
//  channel   dir   beat contents
//  -------   ---   -------------------------------------------------------------
//  s_axis    in    tdata: pressure_pa, temperature_centi, timestamp_ms; tuser: reading_ok
//  m_axis    out   tdata: pressure_mmhg_centi, air_density, trend_centi, forecast
//                  tuser: valid_res
//  apb       cfg   sensor_ready, trend_threshold, min_span_ms, pressure_low, pressure_high
//
//  One reading at a time. A rejected reading goes straight from its accept to S_EMIT and
//  the output register. An accepted one runs 3 or 4 products on the serial multiplier and
//  2 or 3 quotients on the serial divider. It is pushed to the history and the oldest
//  entry is read back. It goes to S_EMIT there when the history is too short for a trend,
//  after S_CHECK when the span is too short, and after the trend product and quotient
//  otherwise. The next beat can be taken as soon as the result sits in the output register;
//  a stalled m_axis holds at most the one finished beat and delays only the load of the next result.
//  Reset clears the registers to their defaults and empties the history at once.
module pressure_trend_forecast_core import ptf_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HIST_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [16:0] pressure_pa, [31:17] temperature_centi,
                                     // [63:32] timestamp_ms
  input  logic        s_axis_tuser,  // [0] reading_ok
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // [16:0] pressure_mmhg_centi, [32:17] air_density,
                                     // [48:33] trend_centi, [50:49] forecast, [55:51] zero
  output logic        m_axis_tuser,  // [0] valid_res
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_MM_MUL = 12'b0000_0000_0010,  // p * 75006
    S_MM_DIV = 12'b0000_0000_0100,  // / 100000
    S_DK_MUL = 12'b0000_0000_1000,  // kelvin * 28705
    S_DN_MUL = 12'b0000_0001_0000,  // p * 1e8
    S_DN_DIV = 12'b0000_0010_0000,  // / (28705 * kelvin)
    S_PUSH   = 12'b0000_0100_0000,
    S_FETCH  = 12'b0000_1000_0000,
    S_CHECK  = 12'b0001_0000_0000,
    S_TR_MUL = 12'b0010_0000_0000,  // |dp| * 3600000
    S_TR_DIV = 12'b0100_0000_0000,  // / dt
    S_EMIT   = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;
  logic   kick, kick_next;

  // config registers
  logic              sensor_ready;
  logic [THR_W-1:0]  trend_threshold;
  logic [SPAN_W-1:0] min_span_ms;
  logic [P_W-1:0]    pressure_low;
  logic [P_W-1:0]    pressure_high;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  // input fields
  logic [P_W-1:0]    in_p;
  logic [TEMP_W-1:0] in_temp;
  logic [TS_W-1:0]   in_ts;
  logic              in_take;
  logic              in_good;

  // working registers
  logic              ok_r;
  logic [P_W-1:0]    p_r;
  logic [TEMP_W-1:0] temp_r;
  logic [TS_W-1:0]   ts_r;
  logic [MMHG_W-1:0] mmhg_r;
  logic [DENS_W-1:0] dens_r;
  logic [30:0]       den_r;
  logic [TRND_W-1:0] trend_r;
  logic [P_W-1:0]    mag_r;
  logic              neg_r;
  logic [TS_W-1:0]   dt_r;

  // serial units
  logic               mul_start, div_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod, quo, div_num;
  logic [DEN_W-1:0]   div_den;
  unit_stat_t         mul_stat, div_stat;

  // history
  logic [P_W-1:0]   old_p;
  logic [TS_W-1:0]  old_t;
  logic [CNT_W-1:0] fill;
  logic             hist_push, hist_fetch;

  // derived
  logic [P_W-1:0]    kelvin;
  logic [TS_W-1:0]   dt_w;
  logic              span_short;
  logic [FC_W-1:0]   fc;
  logic signed [16:0] trend_x, thr_x;
  logic              out_load;

  // ---------------------------------------------------------------- register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_ready    <= RST_SENSOR_READY;
      trend_threshold <= RST_THRESHOLD;
      min_span_ms     <= RST_MIN_SPAN;
      pressure_low    <= RST_P_LOW;
      pressure_high   <= RST_P_HIGH;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SENSOR_READY: sensor_ready    <= pwdata[0];
        REG_THRESHOLD:    trend_threshold <= pwdata[THR_W-1:0];
        REG_MIN_SPAN:     min_span_ms     <= pwdata[SPAN_W-1:0];
        REG_P_LOW:        pressure_low    <= pwdata[P_W-1:0];
        REG_P_HIGH:       pressure_high   <= pwdata[P_W-1:0];
        default: ;  // unmapped, dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SENSOR_READY: prdata = 32'(sensor_ready);
      REG_THRESHOLD:    prdata = 32'(trend_threshold);
      REG_MIN_SPAN:     prdata = 32'(min_span_ms);
      REG_P_LOW:        prdata = 32'(pressure_low);
      REG_P_HIGH:       prdata = 32'(pressure_high);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input side
  assign in_p    = s_axis_tdata[16:0];
  assign in_temp = s_axis_tdata[31:17];
  assign in_ts   = s_axis_tdata[63:32];

  assign s_axis_tready = (state == S_IDLE);
  assign in_take       = s_axis_tvalid & s_axis_tready;
  assign in_good       = sensor_ready & s_axis_tuser &
                         (in_p >= pressure_low) & (in_p <= pressure_high);

  // temperature is sign-extended; the kelvin sum stays positive for any pattern
  assign kelvin = {{(P_W-TEMP_W){temp_r[TEMP_W-1]}}, temp_r} + KELVIN_OFS;

  // newest sample is the one just taken, so only the oldest is read back
  assign dt_w       = ts_r - old_t;
  assign span_short = (dt_w == '0) | (dt_w < TS_W'(min_span_ms));

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    kick_next  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          state_next = in_good ? S_MM_MUL : S_EMIT;
          kick_next  = in_good;
        end
      end
      S_MM_MUL: begin
        if (mul_stat.done) begin
          state_next = S_MM_DIV;
          kick_next  = 1'b1;
        end
      end
      S_MM_DIV: begin
        if (div_stat.done) begin
          state_next = S_DK_MUL;
          kick_next  = 1'b1;
        end
      end
      S_DK_MUL: begin
        if (mul_stat.done) begin
          state_next = S_DN_MUL;
          kick_next  = 1'b1;
        end
      end
      S_DN_MUL: begin
        if (mul_stat.done) begin
          state_next = S_DN_DIV;
          kick_next  = 1'b1;
        end
      end
      S_DN_DIV: begin
        if (div_stat.done) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        state_next = S_FETCH;
      end
      S_FETCH: begin
        state_next = (fill < CNT_W'(2)) ? S_EMIT : S_CHECK;
      end
      S_CHECK: begin
        state_next = span_short ? S_EMIT : S_TR_MUL;
        kick_next  = !span_short;
      end
      S_TR_MUL: begin
        if (mul_stat.done) begin
          state_next = S_TR_DIV;
          kick_next  = 1'b1;
        end
      end
      S_TR_DIV: begin
        if (div_stat.done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kick  <= 1'b0;
    end else begin
      state <= state_next;
      kick  <= kick_next;
    end
  end

  // ---------------------------------------------------------------- unit operands
  assign mul_start = kick & ((state == S_MM_MUL) | (state == S_DK_MUL) |
                             (state == S_DN_MUL) | (state == S_TR_MUL));
  assign div_start = kick & ((state == S_MM_DIV) | (state == S_DN_DIV) |
                             (state == S_TR_DIV));

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_num = '0;
    div_den = '0;
    case (state)
      S_MM_MUL: begin
        mul_a = MMHG_MUL;
        mul_b = p_r;
      end
      S_DK_MUL: begin
        mul_a = DENS_GAS;
        mul_b = kelvin;
      end
      S_DN_MUL: begin
        mul_a = DENS_SCALE;
        mul_b = p_r;
      end
      S_TR_MUL: begin
        mul_a = TREND_SCALE;
        mul_b = mag_r;
      end
      // round to nearest: add half the divisor
      S_MM_DIV: begin
        div_num = prod + MMHG_RND;
        div_den = MMHG_DIV;
      end
      S_DN_DIV: begin
        div_num = prod + PROD_W'(den_r >> 1);
        div_den = DEN_W'(den_r);
      end
      S_TR_DIV: begin
        div_num = prod + PROD_W'(dt_r >> 1);
        div_den = dt_r;
      end
      default: ;
    endcase
  end

  ptf_smul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .stat  (mul_stat)
  );

  ptf_sdiv u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .stat  (div_stat)
  );

  assign hist_push  = (state == S_PUSH);
  assign hist_fetch = (state == S_FETCH) & (fill >= CNT_W'(2));

  ptf_hist #(.DEPTH(HISTORY_DEPTH)) u_hist (
    .clk           (clk),
    .rst           (rst),
    .push          (hist_push),
    .push_pressure (p_r),
    .push_time     (ts_r),
    .fetch         (hist_fetch),
    .old_pressure  (old_p),
    .old_time      (old_t),
    .fill          (fill)
  );

  // ---------------------------------------------------------------- working registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      ok_r    <= in_good;
      p_r     <= in_p;
      temp_r  <= in_temp;
      ts_r    <= in_ts;
      mmhg_r  <= '0;
      dens_r  <= '0;
      trend_r <= '0;
    end
    if (state == S_MM_DIV && div_stat.done) begin
      mmhg_r <= quo[MMHG_W-1:0];
    end
    if (state == S_DK_MUL && mul_stat.done) begin
      den_r <= prod[30:0];
    end
    if (state == S_DN_DIV && div_stat.done) begin
      dens_r <= (quo > PROD_W'(16'hFFFF)) ? '1 : quo[DENS_W-1:0];
    end
    if (state == S_CHECK) begin
      dt_r  <= dt_w;
      neg_r <= p_r < old_p;
      mag_r <= (p_r < old_p) ? old_p - p_r : p_r - old_p;
    end
    // saturate to the signed 16-bit range
    if (state == S_TR_DIV && div_stat.done) begin
      if (neg_r) begin
        trend_r <= (quo > PROD_W'(32768)) ? 16'h8000 : TRND_W'(~quo[15:0] + 16'd1);
      end else begin
        trend_r <= (quo > PROD_W'(32767)) ? 16'h7FFF : quo[TRND_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- forecast, output
  assign trend_x = $signed({trend_r[TRND_W-1], trend_r});
  assign thr_x   = $signed({2'b00, trend_threshold});

  always_comb begin
    if (!ok_r || fill < CNT_W'(3)) begin
      fc = FC_NONE;
    end else if (trend_x > thr_x) begin
      fc = FC_CLEAR;
    end else if (trend_x < -thr_x) begin
      fc = FC_RAIN;
    end else begin
      fc = FC_CHANGE;
    end
  end

  assign out_load = (state == S_EMIT) & (!m_axis_tvalid | m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tuser <= ok_r;
      m_axis_tdata <= {5'b0, fc, trend_r, dens_r, mmhg_r};
    end
  end

  // ---------------------------------------------------------------- assertions
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider running together");

  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (state == S_MM_MUL || state == S_DK_MUL ||
                       state == S_DN_MUL || state == S_TR_MUL))
    else $error("product finished outside a multiply step");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("rejected reading carries nonzero fields");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(HISTORY_DEPTH))
    else $error("history fill count beyond depth");

endmodule
